// ----- hdl/wsrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrs_pkg
// Shared types, codes and constants of the work stealing range scheduler.
// ----------------------------------------------------------------------------
package wsrs_pkg;

   localparam int MAX_WORKERS_DEF = 8;
   localparam int DEQUE_DEPTH_DEF = 4;

   localparam int OPCODE_W   = 2;
   localparam int WORKER_W   = 3;
   localparam int INDEX_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int CSR_DATA_W = 4;
   localparam int CSR_ADDR_W = 1;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;
   localparam int RNG_W      = 64;
   localparam int ENTRY_W    = 2 * INDEX_W;

   localparam logic [RNG_W-1:0]   RNG_MUL    = 64'd2654435761;
   localparam logic [INDEX_W-1:0] COST_FLOOR = 32'd4;

   localparam logic [CSR_ADDR_W-1:0] CSR_WORKER_COUNT = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COST_AWARE   = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ASSIGN = 2'd0,
      OP_POP    = 2'd1,
      OP_STEAL  = 2'd2,
      OP_RETIRE = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NO_VICTIM = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // one xorshift64 advance: <<13, >>7, <<17
   function automatic logic [RNG_W-1:0] xorshift(input logic [RNG_W-1:0] s);
      logic [RNG_W-1:0] a;
      logic [RNG_W-1:0] b;
      a = s ^ (s << 13);
      b = a ^ (a >> 7);
      return b ^ (b << 17);
   endfunction

endpackage

// ----- hdl/wsrs_mod_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrs_mod_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module wsrs_mod_unit #(
   parameter int DW = 64,
   parameter int MW = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [MW-1:0] divisor,
   output logic          done,
   output logic [MW-1:0] remainder
);
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] sh_ff, sh_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [MW-1:0] div_ff, div_in;
   logic [MW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, sh_ff[DW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         sh_in   = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits MW bits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = MW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[MW-1:0];
         end
         sh_in  = sh_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- hdl/wsrs_range_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrs_range_store
// Range entry memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module wsrs_range_store #(
   parameter int ENTRIES = 32,
   parameter int AW      = 5
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [wsrs_pkg::ENTRY_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [wsrs_pkg::ENTRY_W-1:0] rd_data
);
   import wsrs_pkg::*;

   logic [ENTRY_W-1:0] mem_ff [ENTRIES];
   logic [ENTRY_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// ----- hdl/work_stealing_range_scheduler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_stealing_range_scheduler_core
// Per-worker ring deques of index ranges with pop, steal, assign and retire.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_tready is low from acceptance until
// the response transfer. Assign and retire run the work-left sweep over the
// remaining counts of the n active workers; pop adds one store read. A
// random-mode steal adds the bit-serial modulo of the 64-bit xorshift value
// by n-1 plus the victim check and store read; a cost-aware steal adds a
// scan for the richest victim instead. All counts share one read port on the
// remaining-work registers and the ranges live in a single-port-read memory.
// Configuration writes land at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module work_stealing_range_scheduler_core #(
   parameter int MAX_WORKERS = wsrs_pkg::MAX_WORKERS_DEF,
   parameter int DEQUE_DEPTH = wsrs_pkg::DEQUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // worker[2:0], start_index[34:3], end_index[66:35], zero fill
   input  logic [wsrs_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode[1:0]
   input  logic [wsrs_pkg::OPCODE_W-1:0]   req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // victim[2:0], range_start[34:3], range_end[66:35], work_left[67], zero fill
   output logic [wsrs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [wsrs_pkg::STATUS_W-1:0]   rsp_tuser,
   input  logic                            csr_we,
   input  logic [wsrs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [wsrs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wsrs_pkg::*;

   localparam int WW  = $clog2(MAX_WORKERS);
   localparam int NW  = $clog2(MAX_WORKERS + 1);
   localparam int PW  = $clog2(2 * DEQUE_DEPTH);
   localparam int SW  = $clog2(DEQUE_DEPTH);
   localparam int ENT = MAX_WORKERS * DEQUE_DEPTH;
   localparam int AW  = $clog2(ENT);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_EXEC   = 8'b0000_0010,
      S_SCAN   = 8'b0000_0100,
      S_MOD    = 8'b0000_1000,
      S_VICTIM = 8'b0001_0000,
      S_READ   = 8'b0010_0000,
      S_SUM    = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // latched request
   opcode_type          op_ff;
   logic [WORKER_W-1:0] wk_ff;
   logic [INDEX_W-1:0]  start_ff, end_ff;

   // configuration
   logic [CSR_DATA_W-1:0] worker_count_ff;
   logic                  cost_aware_ff;

   // per-worker state
   logic [PW-1:0]      top_ff [MAX_WORKERS];
   logic [PW-1:0]      bot_ff [MAX_WORKERS];
   logic [INDEX_W-1:0] rem_ff [MAX_WORKERS];
   logic [RNG_W-1:0]   rng_ff [MAX_WORKERS];

   // result
   status_type         status_ff, status_in;
   logic [WW-1:0]      victim_ff, victim_in;
   logic [INDEX_W-1:0] rs_ff, rs_in, re_ff, re_in;
   logic               left_ff, left_in;

   // scan bookkeeping
   logic [NW-1:0]      idx_ff, idx_in;
   logic [WW-1:0]      best_ff, best_in;
   logic               best_vld_ff, best_vld_in;
   logic [INDEX_W-1:0] best_work_ff, best_work_in;

   // array write strobes
   logic               top_we, bot_we, rem_we, rng_we;
   logic [PW-1:0]      top_wd, bot_wd;
   logic [INDEX_W-1:0] rem_wd;
   logic [RNG_W-1:0]   rng_wd;

   // decoded values
   logic [31:0]        w32, n32, idx32, v32;
   logic [WW-1:0]      w_idx, ptr_sel, rem_sel;
   logic [NW-1:0]      n_act, idx_nx;
   logic               w_bad;
   logic [PW-1:0]      tp_rd, bp_rd, bp_dec, tp_inc, slot_p;
   logic [SW-1:0]      slot;
   logic [INDEX_W-1:0] rem_rd, len;
   logic [RNG_W-1:0]   rng_nx;
   logic               cand, fin_vld;
   logic [WW-1:0]      fin_idx;

   // memory and modulo unit hookups
   logic               mem_we;
   logic [AW-1:0]      mem_wa, mem_ra, mem_base;
   logic [ENTRY_W-1:0] mem_wd, mem_rd;
   logic               mod_start, mod_done;
   logic [NW-1:0]      mod_rem;

   wsrs_range_store #(
      .ENTRIES (ENT),
      .AW      (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   wsrs_mod_unit #(
      .DW (RNG_W),
      .MW (NW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rng_nx),
      .divisor   (NW'(n_act - 1'b1)),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // worker and active-count decode
   assign w32   = {29'd0, wk_ff};
   assign w_idx = w32[WW-1:0];
   assign w_bad = (w32 >= 32'(MAX_WORKERS));
   always_comb begin
      if (worker_count_ff == '0) begin
         n32 = 32'd1;
      end else if (32'(worker_count_ff) > 32'(MAX_WORKERS)) begin
         n32 = 32'(MAX_WORKERS);
      end else begin
         n32 = 32'(worker_count_ff);
      end
   end
   assign n_act = n32[NW-1:0];

   // pointer port: victim in the victim step, otherwise the requester
   assign ptr_sel = state_ff == S_VICTIM ? victim_ff : w_idx;
   assign tp_rd   = top_ff[ptr_sel];
   assign bp_rd   = bot_ff[ptr_sel];
   assign bp_dec  = bp_rd == '0 ? PW'(2 * DEQUE_DEPTH - 1) : bp_rd - 1'b1;
   assign tp_inc  = tp_rd == PW'(2 * DEQUE_DEPTH - 1) ? '0 : tp_rd + 1'b1;
   assign slot_p  = state_ff == S_VICTIM ? tp_rd : bp_dec;
   always_comb begin
      if (slot_p >= PW'(DEQUE_DEPTH)) begin
         slot = SW'(slot_p - PW'(DEQUE_DEPTH));
      end else begin
         slot = slot_p[SW-1:0];
      end
   end
   assign mem_base = AW'(ptr_sel) * AW'(DEQUE_DEPTH);

   // remaining-count port: sweep index during scans
   assign idx32   = 32'(idx_ff);
   assign rem_sel = (state_ff == S_SCAN || state_ff == S_SUM) ? idx32[WW-1:0] : w_idx;
   assign rem_rd  = rem_ff[rem_sel];
   assign idx_nx  = idx_ff + 1'b1;

   assign len    = end_ff > start_ff ? end_ff - start_ff : '0;
   assign rng_nx = xorshift(rng_ff[w_idx]);

   // cost-aware candidate: strictly richer, never the thief itself
   assign cand    = (idx32 != w32) && (rem_rd > best_work_ff);
   assign fin_vld = best_vld_ff | cand;
   assign fin_idx = cand ? idx32[WW-1:0] : best_ff;
   assign v32     = (32'(mod_rem) >= w32) ? 32'(mod_rem) + 32'd1 : 32'(mod_rem);

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = state_ff == S_OUT;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      victim_in    = victim_ff;
      rs_in        = rs_ff;
      re_in        = re_ff;
      left_in      = left_ff;
      idx_in       = '0;
      best_in      = best_ff;
      best_vld_in  = best_vld_ff;
      best_work_in = best_work_ff;
      top_we       = 1'b0;
      top_wd       = tp_inc;
      bot_we       = 1'b0;
      bot_wd       = bp_dec;
      rem_we       = 1'b0;
      rem_wd       = len;
      rng_we       = 1'b0;
      rng_wd       = rng_nx;
      mem_we       = 1'b0;
      mem_wa       = mem_base;
      mem_wd       = {end_ff, start_ff};
      mem_ra       = mem_base + AW'(slot);
      mod_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in  = S_EXEC;
               status_in = ST_OK;
               victim_in = '0;
               rs_in     = '0;
               re_in     = '0;
               left_in   = 1'b0;
            end
         end
         S_EXEC: begin
            state_in = S_SUM;
            if (w_bad) begin
               if (op_ff == OP_POP) begin
                  status_in = ST_EMPTY;
               end else if (op_ff == OP_STEAL) begin
                  status_in = ST_NO_VICTIM;
               end
            end else begin
               unique case (op_ff)
                  OP_ASSIGN: begin
                     // fresh deque: entry goes to slot 0, a full deque cannot occur
                     top_we = 1'b1;
                     top_wd = '0;
                     bot_we = 1'b1;
                     bot_wd = len != '0 ? PW'(1) : '0;
                     rem_we = 1'b1;
                     mem_we = len != '0;
                  end
                  OP_POP: begin
                     victim_in = w_idx;
                     if (bp_rd == tp_rd) begin
                        status_in = ST_EMPTY;
                     end else begin
                        bot_we   = 1'b1;
                        state_in = S_READ;
                     end
                  end
                  OP_STEAL: begin
                     if (n_act <= NW'(1)) begin
                        status_in = ST_NO_VICTIM;
                     end else begin
                        rng_we = 1'b1;
                        if (cost_aware_ff) begin
                           best_vld_in  = 1'b0;
                           best_in      = '0;
                           best_work_in = COST_FLOOR;
                           state_in     = S_SCAN;
                        end else begin
                           mod_start = 1'b1;
                           state_in  = S_MOD;
                        end
                     end
                  end
                  OP_RETIRE: begin
                     rem_we = 1'b1;
                     rem_wd = rem_rd > len ? rem_rd - len : '0;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            best_vld_in = fin_vld;
            best_in     = fin_idx;
            if (cand) begin
               best_work_in = rem_rd;
            end
            if (idx_nx == n_act) begin
               if (fin_vld) begin
                  victim_in = fin_idx;
                  state_in  = S_VICTIM;
               end else begin
                  status_in = ST_NO_VICTIM;
                  state_in  = S_SUM;
               end
            end else begin
               idx_in = idx_nx;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               victim_in = v32[WW-1:0];
               state_in  = S_VICTIM;
            end
         end
         S_VICTIM: begin
            if (bp_rd == tp_rd) begin
               status_in = ST_EMPTY;
               state_in  = S_SUM;
            end else begin
               top_we   = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            rs_in    = mem_rd[INDEX_W-1:0];
            re_in    = mem_rd[ENTRY_W-1:INDEX_W];
            state_in = S_SUM;
         end
         S_SUM: begin
            left_in = left_ff | (rem_rd != '0);
            if (idx_nx == n_act) begin
               state_in = S_OUT;
            end else begin
               idx_in = idx_nx;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         worker_count_ff <= CSR_DATA_W'(8);
         cost_aware_ff   <= 1'b0;
         for (int i = 0; i < MAX_WORKERS; i++) begin
            top_ff[i] <= '0;
            bot_ff[i] <= '0;
            rem_ff[i] <= '0;
            rng_ff[i] <= RNG_W'(i + 1) * RNG_MUL;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_WORKER_COUNT: worker_count_ff <= csr_wdata;
               CSR_COST_AWARE:   cost_aware_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         if (top_we) top_ff[ptr_sel] <= top_wd;
         if (bot_we) bot_ff[ptr_sel] <= bot_wd;
         if (rem_we) rem_ff[w_idx] <= rem_wd;
         if (rng_we) rng_ff[w_idx] <= rng_wd;
      end
      if (state_ff == S_IDLE && req_tvalid) begin
         op_ff    <= opcode_type'(req_tuser);
         wk_ff    <= req_tdata[WORKER_W-1:0];
         start_ff <= req_tdata[WORKER_W+INDEX_W-1:WORKER_W];
         end_ff   <= req_tdata[WORKER_W+2*INDEX_W-1:WORKER_W+INDEX_W];
      end
      status_ff    <= status_in;
      victim_ff    <= victim_in;
      rs_ff        <= rs_in;
      re_ff        <= re_in;
      left_ff      <= left_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_vld_ff  <= best_vld_in;
      best_work_ff <= best_work_in;
   end

   logic [31:0] vout32;
   assign vout32    = 32'(victim_ff);
   assign rsp_tuser = status_ff;
   assign rsp_tdata = {4'd0, left_ff, re_ff, rs_ff, vout32[2:0]};

endmodule
